// ===== rtl/cpl_pkg.sv =====
`timescale 1ns / 1ps
package cpl_pkg;

  // fixed field widths
  localparam int OP_W       = 3;
  localparam int SONG_W     = 16;
  localparam int TITLE_W    = 32;
  localparam int DUR_W      = 16;
  localparam int POS_W      = 8;
  localparam int POS_CNT_W  = $clog2(POS_W);
  localparam int STATUS_W   = 2;

  // operation codes
  localparam logic [OP_W-1:0] OP_APPEND = 3'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 3'd1;
  localparam logic [OP_W-1:0] OP_NEXT   = 3'd2;
  localparam logic [OP_W-1:0] OP_PREV   = 3'd3;
  localparam logic [OP_W-1:0] OP_REWIND = 3'd4;
  localparam logic [OP_W-1:0] OP_LIST   = 3'd5;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // store read address select
  typedef enum logic [2:0] {
    RA_CURSOR,
    RA_HEAD,
    RA_PTR,
    RA_NEXTQ,
    RA_PREVQ
  } rd_sel_t;

  // controller to datapath commands
  typedef struct packed {
    logic                latch_in;
    logic                rd_en;
    rd_sel_t             rd_sel;
    logic                scan_clr;
    logic                scan_inc;
    logic                app_w1;
    logic                app_w2;
    logic                div_init;
    logic                div_step;
    logic                walk_init;
    logic                walk_adv;
    logic                rem_unlink;
    logic                rem_clear;
    logic                cur_from_next;
    logic                cur_from_prev;
    logic                list_init;
    logic                list_dec;
    logic                out_load;
    logic                out_rec;
    logic [STATUS_W-1:0] out_status;
    logic                out_last;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            count_zero;
    logic            count_one;
    logic            count_full;
    logic            scan_used;
    logic            div_last;
    logic            steps_zero;
    logic            left_one;
    logic            out_free;
  } sts_t;

endpackage

// ===== rtl/cpl_ram.sv =====
`timescale 1ns / 1ps
module cpl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/cpl_datapath.sv =====
`timescale 1ns / 1ps
module cpl_datapath #(
  parameter int CAPACITY = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  cpl_pkg::cmd_t                       cmd,
  output cpl_pkg::sts_t                       sts,
  input  logic [cpl_pkg::OP_W-1:0]            in_op,
  input  logic [cpl_pkg::SONG_W-1:0]          in_song_number,
  input  logic [cpl_pkg::TITLE_W-1:0]         in_title_tag,
  input  logic [cpl_pkg::DUR_W-1:0]           in_duration,
  input  logic [cpl_pkg::POS_W-1:0]           in_position,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [cpl_pkg::STATUS_W-1:0]        out_status,
  output logic [cpl_pkg::SONG_W-1:0]          out_song_number,
  output logic [cpl_pkg::TITLE_W-1:0]         out_title_tag,
  output logic [cpl_pkg::DUR_W-1:0]           out_duration,
  output logic                                out_last
);

  localparam int SW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  // latched transaction
  logic [cpl_pkg::OP_W-1:0]    op_r;
  logic [cpl_pkg::SONG_W-1:0]  song_r;
  logic [cpl_pkg::TITLE_W-1:0] title_r;
  logic [cpl_pkg::DUR_W-1:0]   dur_r;
  logic [cpl_pkg::POS_W-1:0]   pos_r;

  // ring state
  logic [CAPACITY-1:0] used_r;
  logic [SW-1:0]       head_r;
  logic [SW-1:0]       cursor_r;
  logic [CW-1:0]       count_r;

  // working registers
  logic [SW-1:0]                 ptr_r;
  logic [SW-1:0]                 scan_r;
  logic [CW-1:0]                 rem_r;
  logic [cpl_pkg::POS_W-1:0]     div_r;
  logic [cpl_pkg::POS_CNT_W-1:0] bit_cnt_r;
  logic [CW-1:0]                 left_r;

  // output register
  logic                          out_valid_r;
  logic [cpl_pkg::STATUS_W-1:0]  out_status_r;
  logic [cpl_pkg::SONG_W-1:0]    out_song_r;
  logic [cpl_pkg::TITLE_W-1:0]   out_title_r;
  logic [cpl_pkg::DUR_W-1:0]     out_dur_r;
  logic                          out_last_r;

  // store ports
  logic [SW-1:0]               rd_addr;
  logic [SW-1:0]               next_q;
  logic [SW-1:0]               prev_q;
  logic [cpl_pkg::SONG_W-1:0]  num_q;
  logic [cpl_pkg::TITLE_W-1:0] title_q;
  logic [cpl_pkg::DUR_W-1:0]   len_q;
  logic                        next_we;
  logic [SW-1:0]               next_waddr;
  logic [SW-1:0]               next_wdata;
  logic                        prev_we;
  logic [SW-1:0]               prev_waddr;
  logic [SW-1:0]               prev_wdata;

  logic                        count_zero;
  logic                        out_free;
  logic [cpl_pkg::POS_W-1:0]   pos_m1;
  logic [CW:0]                 trial;
  logic [CW:0]                 trial_diff;
  logic                        trial_ge;

  assign count_zero = (count_r == '0);
  assign out_free   = !out_valid_r || out_ready;
  assign pos_m1     = (pos_r == '0) ? '0 : pos_r - cpl_pkg::POS_W'(1);

  // restoring remainder step
  assign trial      = {rem_r, div_r[cpl_pkg::POS_W-1]};
  assign trial_diff = trial - {1'b0, count_r};
  assign trial_ge   = (trial >= {1'b0, count_r});

  // read address select
  always_comb begin
    case (cmd.rd_sel)
      cpl_pkg::RA_CURSOR: rd_addr = cursor_r;
      cpl_pkg::RA_HEAD:   rd_addr = head_r;
      cpl_pkg::RA_PTR:    rd_addr = ptr_r;
      cpl_pkg::RA_NEXTQ:  rd_addr = next_q;
      cpl_pkg::RA_PREVQ:  rd_addr = prev_q;
      default:            rd_addr = head_r;
    endcase
  end

  // link write ports: the tail and the unlink predecessor both come from prev_q
  always_comb begin
    next_we    = cmd.app_w1 || cmd.app_w2 || cmd.rem_unlink;
    next_waddr = cmd.app_w1 ? scan_r : prev_q;
    if (cmd.app_w1) begin
      next_wdata = count_zero ? scan_r : head_r;
    end else if (cmd.app_w2) begin
      next_wdata = scan_r;
    end else begin
      next_wdata = next_q;
    end
    prev_we = cmd.app_w1 || cmd.app_w2 || cmd.rem_unlink;
    if (cmd.app_w1) begin
      prev_waddr = scan_r;
      prev_wdata = count_zero ? scan_r : prev_q;
    end else if (cmd.app_w2) begin
      prev_waddr = head_r;
      prev_wdata = scan_r;
    end else begin
      prev_waddr = next_q;
      prev_wdata = prev_q;
    end
  end

  cpl_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_next_ram (
    .clk(clk), .we(next_we), .waddr(next_waddr), .wdata(next_wdata),
    .re(cmd.rd_en), .raddr(rd_addr), .rdata(next_q)
  );

  cpl_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_prev_ram (
    .clk(clk), .we(prev_we), .waddr(prev_waddr), .wdata(prev_wdata),
    .re(cmd.rd_en), .raddr(rd_addr), .rdata(prev_q)
  );

  cpl_ram #(.WIDTH(cpl_pkg::SONG_W), .DEPTH(CAPACITY)) u_num_ram (
    .clk(clk), .we(cmd.app_w1), .waddr(scan_r), .wdata(song_r),
    .re(cmd.rd_en), .raddr(rd_addr), .rdata(num_q)
  );

  cpl_ram #(.WIDTH(cpl_pkg::TITLE_W), .DEPTH(CAPACITY)) u_title_ram (
    .clk(clk), .we(cmd.app_w1), .waddr(scan_r), .wdata(title_r),
    .re(cmd.rd_en), .raddr(rd_addr), .rdata(title_q)
  );

  cpl_ram #(.WIDTH(cpl_pkg::DUR_W), .DEPTH(CAPACITY)) u_len_ram (
    .clk(clk), .we(cmd.app_w1), .waddr(scan_r), .wdata(dur_r),
    .re(cmd.rd_en), .raddr(rd_addr), .rdata(len_q)
  );

  // transaction latch and working registers
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      op_r    <= in_op;
      song_r  <= in_song_number;
      title_r <= in_title_tag;
      dur_r   <= in_duration;
      pos_r   <= in_position;
    end
    if (cmd.scan_clr) begin
      scan_r <= '0;
    end else if (cmd.scan_inc) begin
      scan_r <= scan_r + SW'(1);
    end
    if (cmd.div_init) begin
      rem_r     <= '0;
      div_r     <= pos_m1;
      bit_cnt_r <= '0;
    end else if (cmd.div_step) begin
      rem_r     <= trial_ge ? trial_diff[CW-1:0] : trial[CW-1:0];
      div_r     <= {div_r[cpl_pkg::POS_W-2:0], 1'b0};
      bit_cnt_r <= bit_cnt_r + cpl_pkg::POS_CNT_W'(1);
    end else if (cmd.walk_adv) begin
      rem_r <= rem_r - CW'(1);
    end
    if (cmd.walk_init || cmd.list_init) begin
      ptr_r <= head_r;
    end else if (cmd.walk_adv) begin
      ptr_r <= next_q;
    end
    if (cmd.list_init) begin
      left_r <= count_r;
    end else if (cmd.list_dec) begin
      left_r <= left_r - CW'(1);
    end
  end

  // ring control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r   <= '0;
      head_r   <= '0;
      cursor_r <= '0;
      count_r  <= '0;
    end else begin
      if (cmd.app_w1) begin
        used_r[scan_r] <= 1'b1;
        if (count_zero) begin
          head_r   <= scan_r;
          cursor_r <= scan_r;
          count_r  <= count_r + CW'(1);
        end
      end else if (cmd.app_w2) begin
        cursor_r <= head_r;
        count_r  <= count_r + CW'(1);
      end else if (cmd.rem_clear) begin
        used_r[ptr_r] <= 1'b0;
        head_r        <= '0;
        cursor_r      <= '0;
        count_r       <= '0;
      end else if (cmd.rem_unlink) begin
        used_r[ptr_r] <= 1'b0;
        count_r       <= count_r - CW'(1);
        if (head_r == ptr_r) begin
          head_r <= next_q;
        end
        if (cursor_r == ptr_r) begin
          cursor_r <= next_q;
        end
      end else if (cmd.cur_from_next) begin
        cursor_r <= next_q;
      end else if (cmd.cur_from_prev) begin
        cursor_r <= prev_q;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r <= cmd.out_status;
      out_last_r   <= cmd.out_last;
      out_song_r   <= cmd.out_rec ? num_q   : '0;
      out_title_r  <= cmd.out_rec ? title_q : '0;
      out_dur_r    <= cmd.out_rec ? len_q   : '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_song_number = out_song_r;
  assign out_title_tag   = out_title_r;
  assign out_duration    = out_dur_r;
  assign out_last        = out_last_r;

  // status to controller
  always_comb begin
    sts.op         = op_r;
    sts.count_zero = count_zero;
    sts.count_one  = (count_r == CW'(1));
    sts.count_full = (count_r == CW'(CAPACITY));
    sts.scan_used  = used_r[scan_r];
    sts.div_last   = (bit_cnt_r == cpl_pkg::POS_CNT_W'(cpl_pkg::POS_W - 1));
    sts.steps_zero = (rem_r == '0);
    sts.left_one   = (left_r == CW'(1));
    sts.out_free   = out_free;
  end

endmodule

// ===== rtl/cpl_ctrl.sv =====
`timescale 1ns / 1ps
module cpl_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  cpl_pkg::sts_t sts,
  output cpl_pkg::cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_A_W1,
    S_A_W2,
    S_DIV,
    S_WALK,
    S_WALK_WAIT,
    S_R_OUT,
    S_R_UNLINK,
    S_N_MOVE,
    S_RW,
    S_EMIT_REC,
    S_L_EMIT,
    S_EMIT_CODE
  } state_t;

  state_t                       state_r, state_nxt;
  logic [cpl_pkg::STATUS_W-1:0] code_r, code_nxt;

  assign in_ready = (state_r == S_IDLE);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    code_nxt  = code_r;
    cmd       = '0;
    cmd.rd_sel = cpl_pkg::RA_HEAD;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.op == cpl_pkg::OP_APPEND) begin
          if (sts.count_full) begin
            code_nxt  = cpl_pkg::ST_FULL;
            state_nxt = S_EMIT_CODE;
          end else begin
            code_nxt     = cpl_pkg::ST_OK;
            cmd.scan_clr = 1'b1;
            state_nxt    = S_SCAN;
          end
        end else if (sts.op > cpl_pkg::OP_LIST) begin
          code_nxt  = cpl_pkg::ST_OK;
          state_nxt = S_EMIT_CODE;
        end else if (sts.count_zero) begin
          code_nxt  = cpl_pkg::ST_EMPTY;
          state_nxt = S_EMIT_CODE;
        end else begin
          case (sts.op)
            cpl_pkg::OP_REMOVE: begin
              cmd.div_init  = 1'b1;
              cmd.walk_init = 1'b1;
              state_nxt     = S_DIV;
            end
            cpl_pkg::OP_NEXT, cpl_pkg::OP_PREV: begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = cpl_pkg::RA_CURSOR;
              state_nxt  = S_N_MOVE;
            end
            cpl_pkg::OP_REWIND: begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = cpl_pkg::RA_HEAD;
              state_nxt  = S_RW;
            end
            default: begin
              cmd.list_init = 1'b1;
              cmd.rd_en     = 1'b1;
              cmd.rd_sel    = cpl_pkg::RA_HEAD;
              state_nxt     = S_L_EMIT;
            end
          endcase
        end
      end
      // lowest free slot, one slot a cycle; head read for the tail link
      S_SCAN: begin
        if (sts.scan_used) begin
          cmd.scan_inc = 1'b1;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = cpl_pkg::RA_HEAD;
          state_nxt  = S_A_W1;
        end
      end
      S_A_W1: begin
        cmd.app_w1 = 1'b1;
        state_nxt  = sts.count_zero ? S_EMIT_CODE : S_A_W2;
      end
      S_A_W2: begin
        cmd.app_w2 = 1'b1;
        state_nxt  = S_EMIT_CODE;
      end
      // position minus one modulo count, one bit a cycle
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = cpl_pkg::RA_PTR;
        state_nxt  = sts.steps_zero ? S_R_OUT : S_WALK_WAIT;
      end
      S_WALK_WAIT: begin
        cmd.walk_adv = 1'b1;
        state_nxt    = S_WALK;
      end
      S_R_OUT: begin
        if (sts.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_rec    = 1'b1;
          cmd.out_status = cpl_pkg::ST_OK;
          cmd.out_last   = 1'b1;
          if (sts.count_one) begin
            cmd.rem_clear = 1'b1;
            state_nxt     = S_IDLE;
          end else begin
            state_nxt = S_R_UNLINK;
          end
        end
      end
      S_R_UNLINK: begin
        cmd.rem_unlink = 1'b1;
        state_nxt      = S_IDLE;
      end
      S_N_MOVE: begin
        cmd.rd_en = 1'b1;
        if (sts.op == cpl_pkg::OP_PREV) begin
          cmd.cur_from_prev = 1'b1;
          cmd.rd_sel        = cpl_pkg::RA_PREVQ;
        end else begin
          cmd.cur_from_next = 1'b1;
          cmd.rd_sel        = cpl_pkg::RA_NEXTQ;
        end
        state_nxt = S_EMIT_REC;
      end
      S_RW: begin
        cmd.cur_from_next = 1'b1;
        state_nxt         = S_EMIT_REC;
      end
      S_EMIT_REC: begin
        if (sts.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_rec    = 1'b1;
          cmd.out_status = cpl_pkg::ST_OK;
          cmd.out_last   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      // one record per transaction, next read issued with each load
      S_L_EMIT: begin
        if (sts.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_rec    = 1'b1;
          cmd.out_status = cpl_pkg::ST_OK;
          cmd.out_last   = sts.left_one;
          if (sts.left_one) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.list_dec = 1'b1;
            cmd.rd_en    = 1'b1;
            cmd.rd_sel   = cpl_pkg::RA_NEXTQ;
          end
        end
      end
      S_EMIT_CODE: begin
        if (sts.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_status = code_r;
          cmd.out_last   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and result code registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      code_r  <= cpl_pkg::ST_OK;
    end else begin
      state_r <= state_nxt;
      code_r  <= code_nxt;
    end
  end

endmodule

// ===== rtl/circular_playlist_list_engine_unit.sv =====
`timescale 1ns / 1ps
// Circular playlist engine: a ring of up to CAPACITY track records with a
// play cursor. One transaction on the in_ channel carries an operation
// (append, remove at position, step next, step previous, rewind, list) and
// causes one result transaction on the out_ channel, or one per record for
// list; out_last marks the final result of each input transaction.
// Items are handled one at a time: in_ready is high only while the engine
// waits for work, and it may rise while the last result still waits in the
// output register.
// Work per item, input accept to result loaded:
//   append   scan from slot 0 past used slots to the lowest free one, then
//            the record and link writes (fewer when the ring is empty)
//   remove   position minus one modulo count by an 8-step remainder unit,
//            a link walk from the head, the result load, then the unlink
//   next, previous, rewind: store reads, cursor move; list: a head read,
//   then one record per output handshake; empty, full, ignored: a code
// Reset (rst_n low at a clock edge) empties the ring and clears head,
// cursor and the output valid flag; the stores need no clearing pass.
// If the receiver stalls, the result holds on the out_ ports and the
// engine waits before loading the next one.
module circular_playlist_list_engine_unit #(
  parameter int CAPACITY = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [cpl_pkg::OP_W-1:0]      in_op,
  input  logic [cpl_pkg::SONG_W-1:0]    in_song_number,
  input  logic [cpl_pkg::TITLE_W-1:0]   in_title_tag,
  input  logic [cpl_pkg::DUR_W-1:0]     in_duration,
  input  logic [cpl_pkg::POS_W-1:0]     in_position,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [cpl_pkg::STATUS_W-1:0]  out_status,
  output logic [cpl_pkg::SONG_W-1:0]    out_song_number,
  output logic [cpl_pkg::TITLE_W-1:0]   out_title_tag,
  output logic [cpl_pkg::DUR_W-1:0]     out_duration,
  output logic                          out_last
);

  cpl_pkg::cmd_t cmd;
  cpl_pkg::sts_t sts;

  // sequencer
  cpl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // ring stores, registers and result register
  cpl_datapath #(.CAPACITY(CAPACITY)) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_op           (in_op),
    .in_song_number  (in_song_number),
    .in_title_tag    (in_title_tag),
    .in_duration     (in_duration),
    .in_position     (in_position),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_song_number (out_song_number),
    .out_title_tag   (out_title_tag),
    .out_duration    (out_duration),
    .out_last        (out_last)
  );

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
module testbench;

  localparam int RING_SLOTS   = 16;
  localparam int SLOT_W       = $clog2(RING_SLOTS);
  localparam int RANDOM_ITEMS = 450;
  localparam int HOLD_CYCLES  = 300;
  localparam int QUIET_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 64;

  // op codes the block ignores
  localparam logic [cpl_pkg::OP_W-1:0] OP_SPARE_A = 3'd6;
  localparam logic [cpl_pkg::OP_W-1:0] OP_SPARE_B = 3'd7;

  typedef logic [SLOT_W-1:0] slot_t;

  typedef struct {
    logic [cpl_pkg::STATUS_W-1:0] status;
    logic [cpl_pkg::SONG_W-1:0]   song;
    logic [cpl_pkg::TITLE_W-1:0]  title;
    logic [cpl_pkg::DUR_W-1:0]    dur;
    logic                         last;
  } track_result_t;

  // ring predictor and store of expected results
  class playlist_scoreboard;
    slot_t                       link_next[RING_SLOTS];
    slot_t                       link_prev[RING_SLOTS];
    bit                          slot_busy[RING_SLOTS];
    logic [cpl_pkg::SONG_W-1:0]  song_at[RING_SLOTS];
    logic [cpl_pkg::TITLE_W-1:0] title_at[RING_SLOTS];
    logic [cpl_pkg::DUR_W-1:0]   length_at[RING_SLOTS];
    slot_t                       head;
    slot_t                       cursor;
    int                          record_count;
    track_result_t               expected_results[$];
    int failures, results_checked;
    int appends, full_hits, empty_hits, removes, lists, longest_list;

    function new();
      head = '0;
      cursor = '0;
      record_count = 0;
      foreach (slot_busy[i]) slot_busy[i] = 1'b0;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function void expect_record(logic [cpl_pkg::STATUS_W-1:0] st, bit has_rec, slot_t s,
                                bit lst);
      track_result_t r;
      r.status = st;
      r.song   = has_rec ? song_at[s] : '0;
      r.title  = has_rec ? title_at[s] : '0;
      r.dur    = has_rec ? length_at[s] : '0;
      r.last   = lst;
      expected_results.push_back(r);
    endfunction

    // work out the results of one accepted input transaction
    function void note_transaction(logic [cpl_pkg::OP_W-1:0] op,
                                   logic [cpl_pkg::SONG_W-1:0] sn,
                                   logic [cpl_pkg::TITLE_W-1:0] tt,
                                   logic [cpl_pkg::DUR_W-1:0] du,
                                   logic [cpl_pkg::POS_W-1:0] pos);
      slot_t walk, free_slot, tail, nx, pv;
      int steps;
      if (op == cpl_pkg::OP_APPEND) begin
        appends++;
        if (record_count >= RING_SLOTS) begin
          full_hits++;
          expect_record(cpl_pkg::ST_FULL, 1'b0, '0, 1'b1);
          return;
        end
        // lowest free slot
        free_slot = '0;
        for (int i = RING_SLOTS - 1; i >= 0; i--)
          if (!slot_busy[i]) free_slot = slot_t'(i);
        slot_busy[free_slot] = 1'b1;
        song_at[free_slot]   = sn;
        title_at[free_slot]  = tt;
        length_at[free_slot] = du;
        if (record_count == 0) begin
          head = free_slot;
          link_next[free_slot] = free_slot;
          link_prev[free_slot] = free_slot;
        end else begin
          // insert in front of the head, i.e. at the tail
          tail = link_prev[head];
          link_next[free_slot] = head;
          link_prev[free_slot] = tail;
          link_next[tail] = free_slot;
          link_prev[head] = free_slot;
        end
        record_count++;
        cursor = head;
        expect_record(cpl_pkg::ST_OK, 1'b0, '0, 1'b1);
      end else if (op > cpl_pkg::OP_LIST) begin
        expect_record(cpl_pkg::ST_OK, 1'b0, '0, 1'b1);
      end else if (record_count == 0) begin
        empty_hits++;
        expect_record(cpl_pkg::ST_EMPTY, 1'b0, '0, 1'b1);
      end else begin
        case (op)
          cpl_pkg::OP_REMOVE: begin
            removes++;
            steps = ((pos == '0) ? 0 : int'(pos) - 1) % record_count;
            walk = head;
            repeat (steps) walk = link_next[walk];
            expect_record(cpl_pkg::ST_OK, 1'b1, walk, 1'b1);
            slot_busy[walk] = 1'b0;
            if (record_count == 1) begin
              record_count = 0;
              head = '0;
              cursor = '0;
            end else begin
              nx = link_next[walk];
              pv = link_prev[walk];
              link_next[pv] = nx;
              link_prev[nx] = pv;
              if (head == walk) head = nx;
              if (cursor == walk) cursor = nx;
              record_count--;
            end
          end
          cpl_pkg::OP_NEXT: begin
            cursor = link_next[cursor];
            expect_record(cpl_pkg::ST_OK, 1'b1, cursor, 1'b1);
          end
          cpl_pkg::OP_PREV: begin
            cursor = link_prev[cursor];
            expect_record(cpl_pkg::ST_OK, 1'b1, cursor, 1'b1);
          end
          cpl_pkg::OP_REWIND: begin
            expect_record(cpl_pkg::ST_OK, 1'b1, head, 1'b1);
            cursor = link_next[head];
          end
          cpl_pkg::OP_LIST: begin
            lists++;
            if (record_count > longest_list) longest_list = record_count;
            walk = head;
            for (int k = 0; k < record_count; k++) begin
              expect_record(cpl_pkg::ST_OK, 1'b1, walk, k == record_count - 1);
              walk = link_next[walk];
            end
          end
          default: begin
          end
        endcase
      end
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("field %s expected %0h got %0h", name, want, got);
        failures++;
      end
    endfunction

    // compare one accepted result with the oldest expectation
    function void check_result(logic [cpl_pkg::STATUS_W-1:0] st,
                               logic [cpl_pkg::SONG_W-1:0] sn,
                               logic [cpl_pkg::TITLE_W-1:0] tt,
                               logic [cpl_pkg::DUR_W-1:0] du, logic lst);
      track_result_t r;
      if (expected_results.size() == 0) begin
        $error("result with nothing expected: status %0h song %0h", st, sn);
        failures++;
        return;
      end
      r = expected_results.pop_front();
      results_checked++;
      compare_field("out_status", 32'(r.status), 32'(st));
      compare_field("out_song_number", 32'(r.song), 32'(sn));
      compare_field("out_title_tag", r.title, tt);
      compare_field("out_duration", 32'(r.dur), 32'(du));
      compare_field("out_last", 32'(r.last), 32'(lst));
    endfunction
  endclass

  logic                         clk;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic [cpl_pkg::OP_W-1:0]     in_op = '0;
  logic [cpl_pkg::SONG_W-1:0]   in_song_number = '0;
  logic [cpl_pkg::TITLE_W-1:0]  in_title_tag = '0;
  logic [cpl_pkg::DUR_W-1:0]    in_duration = '0;
  logic [cpl_pkg::POS_W-1:0]    in_position = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [cpl_pkg::STATUS_W-1:0] out_status;
  logic [cpl_pkg::SONG_W-1:0]   out_song_number;
  logic [cpl_pkg::TITLE_W-1:0]  out_title_tag;
  logic [cpl_pkg::DUR_W-1:0]    out_duration;
  logic                         out_last;

  playlist_scoreboard sb = new();

  int tx_idle_pct = 27;
  int rx_idle_pct = 54;
  bit hold_request = 1'b0;
  int hold_left = 0;
  int holds_done = 0;
  int sent_random = 0;
  int quiet_cycles = 0;

  circular_playlist_list_engine_unit #(.CAPACITY(RING_SLOTS)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_op(in_op),
    .in_song_number(in_song_number),
    .in_title_tag(in_title_tag),
    .in_duration(in_duration),
    .in_position(in_position),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_status(out_status),
    .out_song_number(out_song_number),
    .out_title_tag(out_title_tag),
    .out_duration(out_duration),
    .out_last(out_last)
  );

  // clock, 12 ns period
  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_request) begin
      hold_left = HOLD_CYCLES;
      hold_request = 1'b0;
      holds_done++;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready = 1'b0;
    end else begin
      out_ready = ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_status, out_song_number, out_title_tag, out_duration, out_last);
  end

  // cycles without any transaction on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("circular_playlist_list_engine_unit test failed");
    $finish;
  end

  // offer one transaction and wait for the handshake; called at a falling edge
  task automatic drive_transaction(logic [cpl_pkg::OP_W-1:0] op,
                                   logic [cpl_pkg::SONG_W-1:0] sn,
                                   logic [cpl_pkg::TITLE_W-1:0] tt,
                                   logic [cpl_pkg::DUR_W-1:0] du,
                                   logic [cpl_pkg::POS_W-1:0] pos);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_op = op;
    in_song_number = sn;
    in_title_tag = tt;
    in_duration = du;
    in_position = pos;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.note_transaction(op, sn, tt, du, pos);
    @(negedge clk);
  endtask

  task automatic issue(logic [cpl_pkg::OP_W-1:0] op, logic [cpl_pkg::POS_W-1:0] pos);
    drive_transaction(op, cpl_pkg::SONG_W'($urandom), $urandom,
                      cpl_pkg::DUR_W'($urandom), pos);
  endtask

  task automatic pause_until_drained();
    in_valid = 1'b0;
    while (sb.pending() > 0) @(negedge clk);
  endtask

  // idling phases and pressure points along the random part
  task automatic random_step(logic [cpl_pkg::OP_W-1:0] op, logic [cpl_pkg::POS_W-1:0] pos);
    if (sent_random == RANDOM_ITEMS / 3) begin
      tx_idle_pct = 54;
      rx_idle_pct = 27;
    end
    if (sent_random == 2 * RANDOM_ITEMS / 3) begin
      tx_idle_pct = 0;
      rx_idle_pct = 0;
    end
    if (sent_random == 100 || sent_random == 2 * RANDOM_ITEMS / 3 + 20)
      hold_request = 1'b1;
    if (sent_random == 220 || sent_random == 420)
      pause_until_drained();
    issue(op, pos);
    sent_random++;
  endtask

  function automatic logic [cpl_pkg::POS_W-1:0] pick_position();
    if ($urandom_range(99) < 80)
      return cpl_pkg::POS_W'($urandom_range(0, 2 * sb.record_count + 1));
    return cpl_pkg::POS_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [cpl_pkg::OP_W-1:0] pick_op();
    int r;
    r = $urandom_range(99);
    if (r < 30) return cpl_pkg::OP_APPEND;
    if (r < 48) return cpl_pkg::OP_REMOVE;
    if (r < 63) return cpl_pkg::OP_NEXT;
    if (r < 78) return cpl_pkg::OP_PREV;
    if (r < 86) return cpl_pkg::OP_REWIND;
    if (r < 95) return cpl_pkg::OP_LIST;
    return $urandom_range(1) ? OP_SPARE_A : OP_SPARE_B;
  endfunction

  initial begin
    int kind;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // every operation but append on an empty ring, and the ignored codes
    issue(cpl_pkg::OP_LIST, 8'd0);
    issue(cpl_pkg::OP_NEXT, 8'd1);
    issue(cpl_pkg::OP_PREV, 8'd2);
    issue(cpl_pkg::OP_REWIND, 8'd3);
    issue(cpl_pkg::OP_REMOVE, 8'd255);
    issue(OP_SPARE_A, 8'd0);
    issue(OP_SPARE_B, 8'd255);
    // single record with all-ones fields: list reports it once
    drive_transaction(cpl_pkg::OP_APPEND, 16'hffff, 32'hffff_ffff, 16'hffff, 8'd0);
    issue(cpl_pkg::OP_LIST, 8'd0);
    issue(cpl_pkg::OP_NEXT, 8'd0);
    issue(cpl_pkg::OP_PREV, 8'd0);
    // removing the only record empties the ring, position zero as one
    issue(cpl_pkg::OP_REMOVE, 8'd0);
    issue(cpl_pkg::OP_REWIND, 8'd0);
    // three records, all-zero fields first
    drive_transaction(cpl_pkg::OP_APPEND, 16'h0000, 32'h0000_0000, 16'h0000, 8'd0);
    drive_transaction(cpl_pkg::OP_APPEND, 16'h1234, $urandom,
                      cpl_pkg::DUR_W'($urandom), 8'd0);
    drive_transaction(cpl_pkg::OP_APPEND, 16'hffff, 32'ha5a5_5a5a, 16'h0000, 8'd0);
    issue(cpl_pkg::OP_REWIND, 8'd0);
    issue(cpl_pkg::OP_PREV, 8'd0);
    // head removed with the cursor on it
    issue(cpl_pkg::OP_REMOVE, 8'd1);
    issue(cpl_pkg::OP_NEXT, 8'd0);
    // position beyond the count wraps
    issue(cpl_pkg::OP_REMOVE, 8'd255);
    drive_transaction(cpl_pkg::OP_APPEND, cpl_pkg::SONG_W'($urandom), $urandom,
                      cpl_pkg::DUR_W'($urandom), 8'd0);
    issue(cpl_pkg::OP_LIST, 8'd0);
    issue(cpl_pkg::OP_REMOVE, 8'd2);
    issue(cpl_pkg::OP_LIST, 8'd0);

    // random sequences: fill to full, drain to empty, mixed bursts
    while (sent_random < RANDOM_ITEMS) begin
      kind = $urandom_range(99);
      if (kind < 15) begin
        while (sb.record_count < RING_SLOTS)
          random_step(cpl_pkg::OP_APPEND, pick_position());
        repeat ($urandom_range(1, 2)) random_step(cpl_pkg::OP_APPEND, pick_position());
      end else if (kind < 30) begin
        while (sb.record_count > 0) random_step(cpl_pkg::OP_REMOVE, pick_position());
        random_step(cpl_pkg::OP_REMOVE + cpl_pkg::OP_W'($urandom_range(0, 4)),
                    pick_position());
      end else begin
        repeat ($urandom_range(5, 15)) random_step(pick_op(), pick_position());
      end
    end

    // let every expected result arrive, then watch for strays
    pause_until_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("checked %0d results from %0d random and 25 directed transactions",
             sb.results_checked, sent_random);
    $display("appends %0d (full %0d), removes %0d, lists %0d (longest %0d), empty %0d, holds %0d",
             sb.appends, sb.full_hits, sb.removes, sb.lists, sb.longest_list,
             sb.empty_hits, holds_done);
    if (sb.failures == 0) begin
      $display("circular_playlist_list_engine_unit test passed");
    end else begin
      $display("circular_playlist_list_engine_unit test failed");
    end
    $finish;
  end

endmodule

// ===== circular_playlist_list_engine_unit.f =====
rtl/cpl_pkg.sv
rtl/cpl_ram.sv
rtl/cpl_datapath.sv
rtl/cpl_ctrl.sv
rtl/circular_playlist_list_engine_unit.sv
bench/testbench.sv
